### hdl/rtcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_pkg
// Shared types, codes and calendar constants for the time counter core.
// ----------------------------------------------------------------------------
package rtcc_pkg;

    typedef logic [1:0] t_kind;

    // Request kinds; the fourth code is idle and changes nothing
    localparam t_kind KIND_TICK   = 2'd0;
    localparam t_kind KIND_MINUTE = 2'd1;
    localparam t_kind KIND_LOAD   = 2'd2;
    localparam t_kind KIND_IDLE   = 2'd3;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [3:0] MONTH_FEB  = 4'd2;
    localparam logic [3:0] MONTH_APR  = 4'd4;
    localparam logic [3:0] MONTH_JUN  = 4'd6;
    localparam logic [3:0] MONTH_SEP  = 4'd9;
    localparam logic [3:0] MONTH_NOV  = 4'd11;
    localparam logic [7:0] YEAR_C100  = 8'd100;
    localparam logic [7:0] YEAR_C200  = 8'd200;

    typedef struct packed {
        t_kind      kind;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
    } t_req;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [7:0] year;
        logic       leap;
    } t_time;

    typedef struct packed {
        logic [5:0] sec_now;
        logic [5:0] min_now;
        logic [4:0] hour_now;
        logic [4:0] day_now;
        logic [3:0] month_now;
        logic [7:0] year_now;
        logic       minute_changed;
    } t_result;

    // Last day of a month
    function automatic logic [4:0] month_last_day(input logic [3:0] month,
                                                  input logic       leap);
        logic [4:0] last;
        begin
            if (month == MONTH_FEB) begin
                last = leap ? 5'd29 : 5'd28;
            end else if (month == MONTH_APR || month == MONTH_JUN ||
                         month == MONTH_SEP || month == MONTH_NOV) begin
                last = 5'd30;
            end else begin
                last = 5'd31;
            end
            return last;
        end
    endfunction

    // Gregorian rule on an 8-bit year: only year 0 is a multiple of 400
    function automatic logic year_is_leap(input logic [7:0] year);
        begin
            return (year[1:0] == 2'b00) && (year != YEAR_C100) && (year != YEAR_C200);
        end
    endfunction

endpackage

### hdl/rtcc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_if
// Request and result channels of the time counter core.
// ----------------------------------------------------------------------------
interface rtcc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;

    modport source (output valid, kind, load_hours, load_minutes, input ready);
    modport sink   (input valid, kind, load_hours, load_minutes, output ready);
endinterface

interface rtcc_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] sec_now;
    logic [5:0] min_now;
    logic [4:0] hour_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic [7:0] year_now;
    logic       minute_changed;

    modport source (output valid, sec_now, min_now, hour_now, day_now, month_now,
                    year_now, minute_changed, input ready);
    modport sink   (input valid, sec_now, min_now, hour_now, day_now, month_now,
                    year_now, minute_changed, output ready);
endinterface

### hdl/rtcc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_in_reg
// Input register: capture a request and hold it until the step stage takes it.
// ----------------------------------------------------------------------------
module rtcc_in_reg
    import rtcc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rtcc_in_if.sink       i_req,
    input  logic          i_take,
    output logic          o_valid,
    output t_req          o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_req;
    logic load_en;

    assign i_req.ready = !r_valid || i_take;
    assign load_en     = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (load_en) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_req <= '{kind: i_req.kind, load_hours: i_req.load_hours,
                       load_minutes: i_req.load_minutes};
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

### hdl/rtcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_step
// Next time and date from the current one and one request.
// ----------------------------------------------------------------------------
module rtcc_step
    import rtcc_pkg::*;
(
    input  t_time i_cur,
    input  t_req  i_req,
    output t_time o_nxt,
    output logic  o_minute_changed
);

    logic       min_step;
    logic       hour_step;
    logic       day_step;
    logic       month_step;
    logic       year_step;
    logic [7:0] year_inc;

    always_comb begin
        o_nxt    = i_cur;
        min_step = 1'b0;

        unique case (i_req.kind)
            KIND_TICK: begin
                if (i_cur.sec >= SEC_LAST) begin
                    o_nxt.sec = '0;
                    min_step  = 1'b1;
                end else begin
                    o_nxt.sec = i_cur.sec + 6'd1;
                end
            end
            KIND_MINUTE: begin
                min_step = 1'b1;
            end
            KIND_LOAD: begin
                o_nxt.hour = (i_req.load_hours > HOUR_LAST) ? HOUR_LAST
                                                             : i_req.load_hours;
                o_nxt.min  = (i_req.load_minutes > MIN_LAST) ? MIN_LAST
                                                              : i_req.load_minutes;
            end
            default: begin
                // idle code: hold everything
            end
        endcase

        // Carry chain through minutes, hours, day, month and year
        hour_step  = min_step && (i_cur.min >= MIN_LAST);
        day_step   = hour_step && (i_cur.hour >= HOUR_LAST);
        month_step = day_step &&
                     (i_cur.day >= month_last_day(i_cur.month, i_cur.leap));
        year_step  = month_step && (i_cur.month >= MONTH_LAST);
        year_inc   = i_cur.year + 8'd1;

        if (min_step) begin
            o_nxt.min = hour_step ? 6'd0 : i_cur.min + 6'd1;
        end
        if (hour_step) begin
            o_nxt.hour = day_step ? 5'd0 : i_cur.hour + 5'd1;
        end
        if (day_step) begin
            o_nxt.day = month_step ? 5'd1 : i_cur.day + 5'd1;
        end
        if (month_step) begin
            o_nxt.month = year_step ? 4'd1 : i_cur.month + 4'd1;
        end
        if (year_step) begin
            o_nxt.year = year_inc;
            o_nxt.leap = year_is_leap(year_inc);
        end
    end

    assign o_minute_changed = (o_nxt.min != i_cur.min);

endmodule

### hdl/calendar_time_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_time_counter_core
// Real-time clock calendar: seconds, minutes, hours, day, month, 8-bit year.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per handshake: a one-second tick, an advance
//   of one minute, or a load of hours and minutes (values above range
//   saturate to 23 h / 59 min). Every request yields exactly one result on
//   o_rsp: the full time and date after the request, plus a flag that is
//   set when the minutes changed.
//   Path: a request is captured in the input register, the step logic
//   works on it there and loads the result register when that register is
//   free or draining, so the answer reaches o_rsp through the input and the
//   result register. Throughput is one request per cycle while the receiver
//   takes results; the whole carry chain from seconds to year is combinational.
//   Reset (synchronous, active low) sets 00:00:00 on day 1, month 1, year 0
//   with the leap flag set, and empties both registers.
//   When the receiver stalls, the result holds on o_rsp; one more request
//   waits in the input register, after which i_req.ready drops.
// ----------------------------------------------------------------------------
module calendar_time_counter_core
    import rtcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtcc_in_if.sink   i_req,
    rtcc_out_if.source o_rsp
);

    logic    s1_valid;
    t_req    s1_req;
    logic    take;

    t_time   r_time;
    t_time   n_time;
    logic    minute_changed;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    // Advance the held request whenever the result register is free or draining
    assign take = s1_valid && (!r_out_valid || o_rsp.ready);

    rtcc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_req   (s1_req)
    );

    rtcc_step u_step (
        .i_cur            (r_time),
        .i_req            (s1_req),
        .o_nxt            (n_time),
        .o_minute_changed (minute_changed)
    );

    // Calendar state: update only when a request is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: 5'd1,
                        month: 4'd1, year: 8'd0, leap: 1'b1};
        end else if (take) begin
            r_time <= n_time;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result register: load the new time alongside the state update
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= '{sec_now: n_time.sec, min_now: n_time.min,
                       hour_now: n_time.hour, day_now: n_time.day,
                       month_now: n_time.month, year_now: n_time.year,
                       minute_changed: minute_changed};
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.sec_now        = r_out.sec_now;
    assign o_rsp.min_now        = r_out.min_now;
    assign o_rsp.hour_now       = r_out.hour_now;
    assign o_rsp.day_now        = r_out.day_now;
    assign o_rsp.month_now      = r_out.month_now;
    assign o_rsp.year_now       = r_out.year_now;
    assign o_rsp.minute_changed = r_out.minute_changed;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar time counter core. A scoreboard keeps
// its own copy of the clock and date, predicts the result of every accepted
// request and compares each returned result field by field, in order. The
// stimulus runs a short directed list, then long random runs of day rollovers
// mixed with ticks, minute advances, clamped loads and no-op requests. Both
// sides idle at random, the receiver holds off once for a long stretch and
// the sender drains the core once mid-run.
// ----------------------------------------------------------------------------
import rtcc_pkg::*;

class calendar_tracker;
    t_time   now;
    t_result expected_q[$];
    int      mismatches;
    int      results_checked;
    int      day_rolls;
    int      month_rolls;
    int      year_rolls;
    int      clamped_loads;
    int      idle_requests;

    function new();
        now = '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1,
                year: 8'd0, leap: 1'b1};
        mismatches      = 0;
        results_checked = 0;
        day_rolls       = 0;
        month_rolls     = 0;
        year_rolls      = 0;
        clamped_loads   = 0;
        idle_requests   = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function bit gregorian_leap(logic [7:0] year);
        int y;
        y = year;
        return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
    endfunction

    function logic [4:0] days_in_month();
        logic [4:0] days;
        case (now.month)
            MONTH_FEB: days = now.leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
            default: days = 5'd31;
        endcase
        return days;
    endfunction

    function void next_day();
        day_rolls++;
        if (now.day >= days_in_month()) begin
            now.day = 5'd1;
            month_rolls++;
            if (now.month == MONTH_LAST) begin
                now.month = 4'd1;
                now.year  = now.year + 8'd1;
                now.leap  = gregorian_leap(now.year);
                year_rolls++;
            end else begin
                now.month = now.month + 4'd1;
            end
        end else begin
            now.day = now.day + 5'd1;
        end
    endfunction

    function void next_minute();
        if (now.min == MIN_LAST) begin
            now.min = 6'd0;
            if (now.hour == HOUR_LAST) begin
                now.hour = 5'd0;
                next_day();
            end else begin
                now.hour = now.hour + 5'd1;
            end
        end else begin
            now.min = now.min + 6'd1;
        end
    endfunction

    // Advance the local calendar by one accepted request and queue its result
    function void note_request(t_req req);
        t_result    want;
        logic [5:0] old_min;
        old_min = now.min;
        case (req.kind)
            KIND_TICK: begin
                if (now.sec == SEC_LAST) begin
                    now.sec = 6'd0;
                    next_minute();
                end else begin
                    now.sec = now.sec + 6'd1;
                end
            end
            KIND_MINUTE: next_minute();
            KIND_LOAD: begin
                if (req.load_hours > HOUR_LAST || req.load_minutes > MIN_LAST)
                    clamped_loads++;
                now.hour = (req.load_hours > HOUR_LAST) ? HOUR_LAST : req.load_hours;
                now.min  = (req.load_minutes > MIN_LAST) ? MIN_LAST : req.load_minutes;
            end
            default: idle_requests++;
        endcase
        want.sec_now        = now.sec;
        want.min_now        = now.min;
        want.hour_now       = now.hour;
        want.day_now        = now.day;
        want.month_now      = now.month;
        want.year_now       = now.year;
        want.minute_changed = (now.min != old_min);
        expected_q.push_back(want);
    endfunction

    function string show(t_result r);
        return $sformatf("%02d:%02d:%02d day %0d month %0d year %0d changed %0d",
                         r.hour_now, r.min_now, r.sec_now, r.day_now, r.month_now,
                         r.year_now, r.minute_changed);
    endfunction

    function void check_result(t_result seen);
        t_result want;
        if (expected_q.size() == 0) begin
            if (mismatches < 10)
                $display("ERROR: result with nothing expected: %s", show(seen));
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        results_checked++;
        if (seen.sec_now !== want.sec_now || seen.min_now !== want.min_now ||
            seen.hour_now !== want.hour_now || seen.day_now !== want.day_now ||
            seen.month_now !== want.month_now || seen.year_now !== want.year_now ||
            seen.minute_changed !== want.minute_changed) begin
            if (mismatches < 10)
                $display("ERROR: result %0d expected %s got %s", results_checked,
                         show(want), show(seen));
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtcc_in_if  req_if ();
    rtcc_out_if rsp_if ();

    calendar_tracker tracker;
    t_result         seen;
    int              requests_sent = 0;
    int              cycle_count   = 0;
    bit              idling_allowed = 1'b0;
    bit              hold_off_req   = 1'b0;

    calendar_time_counter_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offer one request from the falling edge and hold it until accepted;
    // a random gap of idle cycles sometimes goes in front when idling is allowed
    task automatic push_request(input t_kind kind, input logic [4:0] hours,
                                input logic [5:0] minutes);
        int   gap;
        t_req req;
        gap = (idling_allowed && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        req = '{kind: kind, load_hours: hours, load_minutes: minutes};
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= req.kind;
        req_if.load_hours   <= req.load_hours;
        req_if.load_minutes <= req.load_minutes;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        tracker.note_request(req);
        requests_sent++;
    endtask

    // Drop valid and hold off until every outstanding result has come back
    task automatic wait_for_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Roll the date: park the clock at the last minute of the day (sometimes
    // with out-of-range load values that clamp) and advance one minute
    task automatic roll_day();
        logic [4:0] hours;
        logic [5:0] minutes;
        hours   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(24, 31)) : HOUR_LAST;
        minutes = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : MIN_LAST;
        push_request(KIND_LOAD, hours, minutes);
        push_request(KIND_MINUTE, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    endtask

    // Pick one random step: a rare run of sixty ticks that wraps the seconds
    // (often from the last minute of the day, so the carry runs into the
    // date), mostly day rollovers, and some fully random requests
    task automatic random_step();
        int pick;
        pick = $urandom_range(0, 199);
        if (pick < 1) begin
            if ($urandom_range(0, 1) == 0)
                push_request(KIND_LOAD, HOUR_LAST, MIN_LAST);
            repeat (60) push_request(KIND_TICK, 5'($urandom_range(0, 31)),
                                     6'($urandom_range(0, 63)));
        end else if (pick < 182) begin
            roll_day();
        end else begin
            push_request(t_kind'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                         6'($urandom_range(0, 63)));
        end
    endtask

    // Receiver: ready changes on the falling edge; random stall bursts, and
    // one long hold-off on request so the core fills and stalls its input
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && idling_allowed && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Sample results on the rising edge and hand them to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            seen.sec_now        = rsp_if.sec_now;
            seen.min_now        = rsp_if.min_now;
            seen.hour_now       = rsp_if.hour_now;
            seen.day_now        = rsp_if.day_now;
            seen.month_now      = rsp_if.month_now;
            seen.year_now       = rsp_if.year_now;
            seen.minute_changed = rsp_if.minute_changed;
            tracker.check_result(seen);
        end
    end

    // Watchdog: end the run if it goes far beyond any correct duration
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        bit hold_done;
        bit drain_done;
        bit lively;
        int next_phase;
        tracker    = new();
        hold_done  = 1'b0;
        drain_done = 1'b0;
        lively     = 1'b1;
        next_phase = 0;

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.kind         = KIND_IDLE;
        req_if.load_hours   = 5'd0;
        req_if.load_minutes = 6'd0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tick and minute from reset, idle kind with and without
        // payload, loads at both ends and beyond range, a minute advance
        // from the last minute of the day, and alternating bit patterns
        push_request(KIND_TICK, 5'd0, 6'd0);
        push_request(KIND_IDLE, 5'd0, 6'd0);
        push_request(KIND_MINUTE, 5'd0, 6'd0);
        push_request(KIND_LOAD, 5'd0, 6'd0);
        push_request(KIND_LOAD, HOUR_LAST, MIN_LAST);
        push_request(KIND_LOAD, 5'd31, 6'd63);
        push_request(KIND_LOAD, 5'd24, 6'd60);
        push_request(KIND_MINUTE, 5'd31, 6'd63);
        push_request(KIND_LOAD, 5'b10101, 6'b101010);
        push_request(KIND_LOAD, 5'b01010, 6'b010101);
        push_request(KIND_IDLE, 5'd31, 6'd63);
        push_request(KIND_TICK, 5'd31, 6'd63);
        push_request(KIND_LOAD, HOUR_LAST, 6'd58);
        push_request(KIND_MINUTE, 5'd0, 6'd0);
        push_request(KIND_MINUTE, 5'd0, 6'd0);

        // Random part: open with one full seconds wrap, then, up to a request cap,
        // keep going until the year has turned and the first non-leap February is past
        push_request(KIND_LOAD, HOUR_LAST, MIN_LAST);
        repeat (60) push_request(KIND_TICK, 5'($urandom_range(0, 31)),
                                 6'($urandom_range(0, 63)));
        while ((requests_sent < RANDOM_ITEMS - QUIET_ITEMS ||
                tracker.now.year == 8'd0 || tracker.now.month < 4'd3) &&
               requests_sent < RANDOM_ITEMS + 600) begin
            if (requests_sent >= next_phase) begin
                next_phase += 100;
                lively = ($urandom_range(0, 3) != 0);
            end
            idling_allowed = lively;
            if (!hold_done && requests_sent >= RANDOM_ITEMS / 3) begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!drain_done && requests_sent >= RANDOM_ITEMS / 2) begin
                drain_done = 1'b1;
                wait_for_results();
            end
            random_step();
        end

        // Quiet tail: same mix, both sides at full rate
        idling_allowed = 1'b0;
        next_phase     = requests_sent + QUIET_ITEMS;
        while (requests_sent < next_phase) random_step();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d requests in %0d cycles",
                 tracker.results_checked, requests_sent, cycle_count);
        $display("Covered %0d day, %0d month, %0d year rollovers, %0d clamped loads,",
                 tracker.day_rolls, tracker.month_rolls, tracker.year_rolls,
                 tracker.clamped_loads);
        $display("and %0d idle requests", tracker.idle_requests);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rtcc_pkg.sv
hdl/rtcc_if.sv
hdl/rtcc_in_reg.sv
hdl/rtcc_step.sv
hdl/calendar_time_counter_core.sv
tb/tb_top.sv
